[design/aabbct_pkg.sv]
`timescale 1ns / 1ps

package aabbct_pkg;

  // operation codes
  localparam logic [1:0] OP_REGISTER   = 2'd0;
  localparam logic [1:0] OP_UNREGISTER = 2'd1;
  localparam logic [1:0] OP_CHECK      = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_PAIR   = 2'd1;
  localparam logic [1:0] KIND_DONE   = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  // pair results per check
  localparam int RESULT_CAP = 29;
  localparam int N_W        = 5;

  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 32;

  typedef struct packed {
    logic [7:0]         id;
    logic [3:0]         type_code;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [14:0]        w;
    logic [14:0]        h;
  } entry_t;

  typedef enum logic [1:0] {
    PUSH_NONE,
    PUSH_STATUS,
    PUSH_PAIR,
    PUSH_DONE
  } push_t;

  typedef struct packed {
    logic       rd_en;
    logic       we;
    logic       wr_src_mem;
    logic       item_ld;
    logic       pend_ld;
    push_t      push;
    logic [1:0] push_status;
    logic       push_last;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic id_match;
    logic out_free;
  } stat_t;

endpackage

[design/aabbct_ctrl.sv]
`timescale 1ns / 1ps

module aabbct_ctrl #(
  parameter int MAX_OBJECTS = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic [1:0]                       in_tuser,
  output logic                             in_tready,
  input  aabbct_pkg::stat_t                stat,
  output aabbct_pkg::cmd_t                 cmd,
  output logic [$clog2(MAX_OBJECTS)-1:0]   rd_a_addr,
  output logic [$clog2(MAX_OBJECTS)-1:0]   rd_b_addr,
  output logic [$clog2(MAX_OBJECTS)-1:0]   wr_addr
);

  localparam int AW = $clog2(MAX_OBJECTS);
  localparam int CW = $clog2(MAX_OBJECTS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RESP,
    S_UN_RD,
    S_UN_CMP,
    S_SH_RD,
    S_SH_WR,
    S_CHK_RUN,
    S_CHK_END
  } state_t;

  state_t                      state_r, state_nxt;
  logic [CW-1:0]               count_r, count_nxt;
  logic [AW-1:0]               i_r, i_nxt;
  logic [AW-1:0]               j_r, j_nxt;
  logic [AW-1:0]               k_r, k_nxt;
  logic [1:0]                  st_r, st_nxt;
  logic                        iss_r, iss_nxt;
  logic                        stage_v_r, stage_v_nxt;
  logic                        pend_v_r, pend_v_nxt;
  logic [aabbct_pkg::N_W-1:0]  n_r, n_nxt;
  logic                        hit_ok;
  logic                        stall;
  logic                        last_k;

  assign in_tready = (state_r == S_IDLE);
  assign hit_ok    = stage_v_r & stat.hit &
                     (n_r < aabbct_pkg::N_W'(aabbct_pkg::RESULT_CAP));
  assign stall     = hit_ok & pend_v_r & ~stat.out_free;
  assign last_k    = ((CW'(k_r) + CW'(1)) == count_r);

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    i_nxt       = i_r;
    j_nxt       = j_r;
    k_nxt       = k_r;
    st_nxt      = st_r;
    iss_nxt     = iss_r;
    stage_v_nxt = stage_v_r;
    pend_v_nxt  = pend_v_r;
    n_nxt       = n_r;
    cmd         = '0;
    cmd.push    = aabbct_pkg::PUSH_NONE;
    rd_a_addr   = i_r;
    rd_b_addr   = j_r;
    wr_addr     = count_r[AW-1:0];
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.item_ld = 1'b1;
          unique case (in_tuser)
            aabbct_pkg::OP_REGISTER: begin
              state_nxt = S_RESP;
              if (count_r == CW'(MAX_OBJECTS)) begin
                st_nxt = aabbct_pkg::ST_FULL;
              end else begin
                cmd.we    = 1'b1;
                count_nxt = count_r + CW'(1);
                st_nxt    = aabbct_pkg::ST_OK;
              end
            end
            aabbct_pkg::OP_UNREGISTER: begin
              k_nxt = '0;
              if (count_r == '0) begin
                st_nxt    = aabbct_pkg::ST_NOT_FOUND;
                state_nxt = S_RESP;
              end else begin
                state_nxt = S_UN_RD;
              end
            end
            aabbct_pkg::OP_CHECK: begin
              i_nxt       = '0;
              j_nxt       = AW'(1);
              iss_nxt     = 1'b1;
              stage_v_nxt = 1'b0;
              pend_v_nxt  = 1'b0;
              n_nxt       = '0;
              state_nxt   = (count_r < CW'(2)) ? S_CHK_END : S_CHK_RUN;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_RESP: begin
        if (stat.out_free) begin
          cmd.push        = aabbct_pkg::PUSH_STATUS;
          cmd.push_status = st_r;
          cmd.push_last   = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      S_UN_RD: begin
        cmd.rd_en = 1'b1;
        rd_a_addr = k_r;
        state_nxt = S_UN_CMP;
      end
      S_UN_CMP: begin
        if (stat.id_match) begin
          if (last_k) begin
            count_nxt = count_r - CW'(1);
            st_nxt    = aabbct_pkg::ST_OK;
            state_nxt = S_RESP;
          end else begin
            state_nxt = S_SH_RD;
          end
        end else if (last_k) begin
          st_nxt    = aabbct_pkg::ST_NOT_FOUND;
          state_nxt = S_RESP;
        end else begin
          k_nxt     = k_r + AW'(1);
          state_nxt = S_UN_RD;
        end
      end
      S_SH_RD: begin
        cmd.rd_en = 1'b1;
        rd_a_addr = AW'(CW'(k_r) + CW'(1));
        state_nxt = S_SH_WR;
      end
      S_SH_WR: begin
        cmd.we         = 1'b1;
        cmd.wr_src_mem = 1'b1;
        wr_addr        = k_r;
        if ((CW'(k_r) + CW'(2)) == count_r) begin
          count_nxt = count_r - CW'(1);
          st_nxt    = aabbct_pkg::ST_OK;
          state_nxt = S_RESP;
        end else begin
          k_nxt     = k_r + AW'(1);
          state_nxt = S_SH_RD;
        end
      end
      S_CHK_RUN: begin
        if (!stall) begin
          cmd.rd_en   = iss_r;
          stage_v_nxt = iss_r;
          if (hit_ok) begin
            cmd.pend_ld = 1'b1;
            n_nxt       = n_r + aabbct_pkg::N_W'(1);
            pend_v_nxt  = 1'b1;
            if (pend_v_r) begin
              cmd.push = aabbct_pkg::PUSH_PAIR;
            end
          end
          if (iss_r) begin
            if ((CW'(j_r) + CW'(1)) == count_r) begin
              if ((CW'(i_r) + CW'(2)) == count_r) begin
                iss_nxt = 1'b0;
              end else begin
                i_nxt = i_r + AW'(1);
                j_nxt = AW'(CW'(i_r) + CW'(2));
              end
            end else begin
              j_nxt = j_r + AW'(1);
            end
          end else begin
            state_nxt = S_CHK_END;
          end
        end
      end
      S_CHK_END: begin
        if (stat.out_free) begin
          cmd.push      = pend_v_r ? aabbct_pkg::PUSH_PAIR : aabbct_pkg::PUSH_DONE;
          cmd.push_last = 1'b1;
          pend_v_nxt    = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      iss_r     <= 1'b0;
      stage_v_r <= 1'b0;
      pend_v_r  <= 1'b0;
      n_r       <= '0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      iss_r     <= iss_nxt;
      stage_v_r <= stage_v_nxt;
      pend_v_r  <= pend_v_nxt;
      n_r       <= n_nxt;
    end
    i_r  <= i_nxt;
    j_r  <= j_nxt;
    k_r  <= k_nxt;
    st_r <= st_nxt;
  end

endmodule

[design/aabbct_datapath.sv]
`timescale 1ns / 1ps

module aabbct_datapath #(
  parameter int MAX_OBJECTS = 8
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic [aabbct_pkg::IN_DATA_W-1:0]       in_tdata,
  input  aabbct_pkg::cmd_t                       cmd,
  input  logic [$clog2(MAX_OBJECTS)-1:0]         rd_a_addr,
  input  logic [$clog2(MAX_OBJECTS)-1:0]         rd_b_addr,
  input  logic [$clog2(MAX_OBJECTS)-1:0]         wr_addr,
  output aabbct_pkg::stat_t                      stat,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output logic [aabbct_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic [1:0]                             out_tuser,
  output logic                                   out_tlast
);

  aabbct_pkg::entry_t mem [MAX_OBJECTS];
  aabbct_pkg::entry_t in_entry;
  aabbct_pkg::entry_t wr_data;
  aabbct_pkg::entry_t rd_a_r;
  aabbct_pkg::entry_t rd_b_r;

  logic [7:0]         item_id_r;
  logic [3:0]         item_type_r;
  logic [7:0]         pend_fid_r;
  logic [3:0]         pend_ftype_r;
  logic [7:0]         pend_sid_r;
  logic [3:0]         pend_stype_r;

  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         out_kind_r;
  logic [1:0]         out_status_r;
  logic [7:0]         out_fid_r;
  logic [3:0]         out_ftype_r;
  logic [7:0]         out_sid_r;
  logic [3:0]         out_stype_r;
  logic               out_last_r;

  logic signed [16:0] ax_lo, ax_hi, ay_lo, ay_hi;
  logic signed [16:0] bx_lo, bx_hi, by_lo, by_hi;

  // tdata: object_id, type_code, pos_x, pos_y, size_w, size_h
  assign in_entry.id        = in_tdata[7:0];
  assign in_entry.type_code = in_tdata[11:8];
  assign in_entry.x         = in_tdata[27:12];
  assign in_entry.y         = in_tdata[43:28];
  assign in_entry.w         = in_tdata[58:44];
  assign in_entry.h         = in_tdata[73:59];

  assign wr_data = cmd.wr_src_mem ? rd_a_r : in_entry;

  always_ff @(posedge clk) begin
    if (cmd.we) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_a_r <= mem[rd_a_addr];
      rd_b_r <= mem[rd_b_addr];
    end
  end

  // closed-interval overlap on both axes, 17-bit edges
  assign ax_lo = {rd_a_r.x[15], rd_a_r.x};
  assign ay_lo = {rd_a_r.y[15], rd_a_r.y};
  assign bx_lo = {rd_b_r.x[15], rd_b_r.x};
  assign by_lo = {rd_b_r.y[15], rd_b_r.y};
  assign ax_hi = ax_lo + $signed({2'b00, rd_a_r.w});
  assign ay_hi = ay_lo + $signed({2'b00, rd_a_r.h});
  assign bx_hi = bx_lo + $signed({2'b00, rd_b_r.w});
  assign by_hi = by_lo + $signed({2'b00, rd_b_r.h});

  assign stat.hit      = (ax_lo <= bx_hi) && (bx_lo <= ax_hi) &&
                         (ay_lo <= by_hi) && (by_lo <= ay_hi);
  assign stat.id_match = (rd_a_r.id == item_id_r);
  assign stat.out_free = ~out_valid_r | out_tready;

  always_ff @(posedge clk) begin
    if (cmd.item_ld) begin
      item_id_r   <= in_entry.id;
      item_type_r <= in_entry.type_code;
    end
    if (cmd.pend_ld) begin
      pend_fid_r   <= rd_a_r.id;
      pend_ftype_r <= rd_a_r.type_code;
      pend_sid_r   <= rd_b_r.id;
      pend_stype_r <= rd_b_r.type_code;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r & ~out_tready;
    if (cmd.push != aabbct_pkg::PUSH_NONE) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    unique case (cmd.push)
      aabbct_pkg::PUSH_STATUS: begin
        out_kind_r   <= aabbct_pkg::KIND_STATUS;
        out_status_r <= cmd.push_status;
        out_fid_r    <= item_id_r;
        out_ftype_r  <= item_type_r;
        out_sid_r    <= '0;
        out_stype_r  <= '0;
        out_last_r   <= 1'b1;
      end
      aabbct_pkg::PUSH_PAIR: begin
        out_kind_r   <= aabbct_pkg::KIND_PAIR;
        out_status_r <= aabbct_pkg::ST_OK;
        out_fid_r    <= pend_fid_r;
        out_ftype_r  <= pend_ftype_r;
        out_sid_r    <= pend_sid_r;
        out_stype_r  <= pend_stype_r;
        out_last_r   <= cmd.push_last;
      end
      aabbct_pkg::PUSH_DONE: begin
        out_kind_r   <= aabbct_pkg::KIND_DONE;
        out_status_r <= aabbct_pkg::ST_OK;
        out_fid_r    <= '0;
        out_ftype_r  <= '0;
        out_sid_r    <= '0;
        out_stype_r  <= '0;
        out_last_r   <= 1'b1;
      end
      aabbct_pkg::PUSH_NONE: begin
        out_kind_r <= out_kind_r;
      end
      default: begin
        out_kind_r <= out_kind_r;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {6'b0, out_stype_r, out_sid_r, out_ftype_r, out_fid_r, out_status_r};

endmodule

[design/aabb_all_pairs_collision_table.sv]
`timescale 1ns / 1ps

// channel | dir | beat fields
// in_     | in  | tuser: operation; tdata: object_id, type_code, pos_x, pos_y, size_w, size_h
// out_    | out | tuser: kind; tlast: last; tdata: status, first_id, first_type,
//         |     |   second_id, second_type
//
// register: the entry is written, then the status beat; unregister: a read and a compare
// per entry searched plus a read and a write per entry moved down, then the status beat.
// the single table read port pair sets this order. check: one pair per cycle unless stalled.
// a new beat is taken only once the previous item's last result is in the output register.
// out_tready low holds the pair scan when a further hit needs the output register.
// reset empties the table at once; no clearing pass.

module aabb_all_pairs_collision_table #(
  parameter int MAX_OBJECTS = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [7:0] object_id, [11:8] type_code, [27:12] pos_x, [43:28] pos_y,
  // [58:44] size_w, [73:59] size_h
  input  logic [aabbct_pkg::IN_DATA_W-1:0]  in_tdata,
  // [1:0] operation
  input  logic [1:0]                        in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [1:0] status, [9:2] first_id, [13:10] first_type, [21:14] second_id,
  // [25:22] second_type
  output logic [aabbct_pkg::OUT_DATA_W-1:0] out_tdata,
  // [1:0] kind
  output logic [1:0]                        out_tuser,
  output logic                              out_tlast
);

  localparam int AW = $clog2(MAX_OBJECTS);

  aabbct_pkg::cmd_t  cmd;
  aabbct_pkg::stat_t stat;
  logic [AW-1:0]     rd_a_addr;
  logic [AW-1:0]     rd_b_addr;
  logic [AW-1:0]     wr_addr;

  aabbct_ctrl #(
    .MAX_OBJECTS (MAX_OBJECTS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tuser  (in_tuser),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd),
    .rd_a_addr (rd_a_addr),
    .rd_b_addr (rd_b_addr),
    .wr_addr   (wr_addr)
  );

  aabbct_datapath #(
    .MAX_OBJECTS (MAX_OBJECTS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .rd_a_addr  (rd_a_addr),
    .rd_b_addr  (rd_b_addr),
    .wr_addr    (wr_addr),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.push != aabbct_pkg::PUSH_NONE) |-> stat.out_free)
    else $error("result pushed into a full output register");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.we |-> (int'(wr_addr) < MAX_OBJECTS))
    else $error("table write beyond last entry");

  a_busy_after_op: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == aabbct_pkg::OP_REGISTER ||
     in_tuser == aabbct_pkg::OP_UNREGISTER || in_tuser == aabbct_pkg::OP_CHECK))
    |=> !in_tready)
    else $error("new beat taken while an item is in progress");

  a_pair_status_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != aabbct_pkg::KIND_STATUS) |->
    (out_tdata[1:0] == aabbct_pkg::ST_OK))
    else $error("pair or done result with nonzero status");

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps

module tb;

  localparam int TABLE_DEPTH  = 8;
  localparam int RANDOM_ITEMS = 160;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 100;

  // operation code the block ignores
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [1:0] kind;
    logic [1:0] status;
    logic [7:0] first_id;
    logic [3:0] first_type;
    logic [7:0] second_id;
    logic [3:0] second_type;
    logic       last;
  } result_beat_t;

  class collision_scoreboard;
    aabbct_pkg::entry_t slots[TABLE_DEPTH];
    int unsigned        fill;
    result_beat_t       awaited[$];
    int                 errors;

    function new();
      fill = 0;
      errors = 0;
    endfunction

    function void push_beat(logic [1:0] kind, logic [1:0] status, logic [7:0] fid,
                            logic [3:0] ftype, logic [7:0] sid, logic [3:0] stype,
                            logic last);
      result_beat_t b;
      b.kind = kind;
      b.status = status;
      b.first_id = fid;
      b.first_type = ftype;
      b.second_id = sid;
      b.second_type = stype;
      b.last = last;
      awaited.push_back(b);
    endfunction

    // closed intervals on both axes, edges at full int width
    function bit boxes_touch(aabbct_pkg::entry_t a, aabbct_pkg::entry_t b);
      int axl, axh, ayl, ayh, bxl, bxh, byl, byh;
      axl = $signed(a.x);
      ayl = $signed(a.y);
      bxl = $signed(b.x);
      byl = $signed(b.y);
      axh = axl + int'(a.w);
      ayh = ayl + int'(a.h);
      bxh = bxl + int'(b.w);
      byh = byl + int'(b.h);
      return axl <= bxh && bxl <= axh && ayl <= byh && byl <= ayh;
    endfunction

    function void note_item(logic [1:0] op, logic [aabbct_pkg::IN_DATA_W-1:0] data);
      aabbct_pkg::entry_t e;
      int                 hit_at;
      int                 hits;
      e.id = data[7:0];
      e.type_code = data[11:8];
      e.x = data[27:12];
      e.y = data[43:28];
      e.w = data[58:44];
      e.h = data[73:59];
      case (op)
        aabbct_pkg::OP_REGISTER: begin
          if (fill == TABLE_DEPTH) begin
            push_beat(aabbct_pkg::KIND_STATUS, aabbct_pkg::ST_FULL, e.id, e.type_code,
                      '0, '0, 1'b1);
          end else begin
            slots[fill] = e;
            fill++;
            push_beat(aabbct_pkg::KIND_STATUS, aabbct_pkg::ST_OK, e.id, e.type_code,
                      '0, '0, 1'b1);
          end
        end
        aabbct_pkg::OP_UNREGISTER: begin
          hit_at = -1;
          for (int i = 0; i < fill; i++)
            if (hit_at < 0 && slots[i].id == e.id) hit_at = i;
          if (hit_at >= 0) begin
            for (int j = hit_at; j + 1 < fill; j++) slots[j] = slots[j + 1];
            fill--;
            push_beat(aabbct_pkg::KIND_STATUS, aabbct_pkg::ST_OK, e.id, e.type_code,
                      '0, '0, 1'b1);
          end else begin
            push_beat(aabbct_pkg::KIND_STATUS, aabbct_pkg::ST_NOT_FOUND, e.id,
                      e.type_code, '0, '0, 1'b1);
          end
        end
        aabbct_pkg::OP_CHECK: begin
          hits = 0;
          for (int i = 0; i < fill; i++)
            for (int j = i + 1; j < fill; j++)
              if (hits < aabbct_pkg::RESULT_CAP && boxes_touch(slots[i], slots[j])) begin
                push_beat(aabbct_pkg::KIND_PAIR, aabbct_pkg::ST_OK, slots[i].id,
                          slots[i].type_code, slots[j].id, slots[j].type_code, 1'b0);
                hits++;
              end
          if (hits == 0) begin
            push_beat(aabbct_pkg::KIND_DONE, aabbct_pkg::ST_OK, '0, '0, '0, '0, 1'b1);
          end else begin
            awaited[awaited.size() - 1].last = 1'b1;
          end
        end
        default: ;
      endcase
    endfunction

    function void compare(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_beat(logic [1:0] kind, logic last,
                             logic [aabbct_pkg::OUT_DATA_W-1:0] data);
      result_beat_t want;
      if (awaited.size() == 0) begin
        $error("unexpected beat: kind %0d tdata %h", kind, data);
        errors++;
        return;
      end
      want = awaited.pop_front();
      compare("kind", want.kind, kind);
      compare("status", want.status, data[1:0]);
      compare("first_id", want.first_id, data[9:2]);
      compare("first_type", want.first_type, data[13:10]);
      compare("second_id", want.second_id, data[21:14]);
      compare("second_type", want.second_type, data[25:22]);
      compare("last", want.last, last);
    endfunction
  endclass

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              in_tvalid = 1'b0;
  logic                              in_tready;
  logic [aabbct_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic [1:0]                        in_tuser = aabbct_pkg::OP_REGISTER;
  logic                              out_tvalid;
  logic                              out_tready = 1'b0;
  logic [aabbct_pkg::OUT_DATA_W-1:0] out_tdata;
  logic [1:0]                        out_tuser;
  logic                              out_tlast;

  logic                              no_gaps = 1'b0;
  int                                cycles = 0;
  collision_scoreboard               sb;

  aabb_all_pairs_collision_table #(
    .MAX_OBJECTS(TABLE_DEPTH)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .out_tlast(out_tlast)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("** aabb_all_pairs_collision_table: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_tready <= no_gaps || ($urandom_range(99) >= 36);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_beat(out_tuser, out_tlast, out_tdata);
  end

  task automatic send_item(input logic [1:0] op, input logic [7:0] id, input logic [3:0] tcode,
                           input logic [15:0] x, input logic [15:0] y,
                           input logic [14:0] w, input logic [14:0] h);
    logic [aabbct_pkg::IN_DATA_W-1:0] beat;
    beat = '0;
    beat[7:0] = id;
    beat[11:8] = tcode;
    beat[27:12] = x;
    beat[43:28] = y;
    beat[58:44] = w;
    beat[73:59] = h;
    if (!no_gaps && $urandom_range(99) < 36) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while (!no_gaps && $urandom_range(99) < 36);
    end
    in_tvalid <= 1'b1;
    in_tdata <= beat;
    in_tuser <= op;
    do @(posedge clk); while (!in_tready);
    sb.note_item(op, beat);
  endtask

  task automatic send_random_item(output bit counted);
    logic [1:0]  op;
    logic [7:0]  id;
    logic [15:0] x, y;
    logic [14:0] w, h;
    int          pick;
    pick = $urandom_range(99);
    if (pick < ((sb.fill == TABLE_DEPTH) ? 10 : 45)) op = aabbct_pkg::OP_REGISTER;
    else if (pick < 70) op = aabbct_pkg::OP_UNREGISTER;
    else if (pick < 95) op = aabbct_pkg::OP_CHECK;
    else op = OP_UNUSED;
    id = ($urandom_range(3) != 0) ? 8'($urandom_range(15)) : 8'($urandom);
    if (op == aabbct_pkg::OP_UNREGISTER && sb.fill > 0 && $urandom_range(9) < 7)
      id = sb.slots[$urandom_range(sb.fill - 1)].id;
    // mostly a crowded patch so that boxes overlap, sometimes the full range
    if ($urandom_range(9) < 8) begin
      x = 16'($urandom_range(400)) - 16'd200;
      y = 16'($urandom_range(400)) - 16'd200;
      w = 15'($urandom_range(300));
      h = 15'($urandom_range(300));
    end else begin
      x = 16'($urandom);
      y = 16'($urandom);
      w = 15'($urandom);
      h = 15'($urandom);
    end
    send_item(op, id, 4'($urandom), x, y, w, h);
    counted = (op != OP_UNUSED);
  endtask

  initial begin
    int done_items;
    bit counted;
    sb = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table
    send_item(aabbct_pkg::OP_CHECK, 8'h00, 4'h0, 16'h0000, 16'h0000, 15'h0000, 15'h0000);
    send_item(aabbct_pkg::OP_UNREGISTER, 8'hff, 4'hf, 16'h7fff, 16'h8000, 15'h7fff,
              15'h0000);
    // corners, containment, touching edges, duplicate id, wide boxes
    send_item(aabbct_pkg::OP_REGISTER, 8'h00, 4'h0, 16'h8000, 16'h8000, 15'h0000,
              15'h0000);
    send_item(aabbct_pkg::OP_REGISTER, 8'hff, 4'hf, 16'h7fff, 16'h7fff, 15'h7fff,
              15'h7fff);
    send_item(aabbct_pkg::OP_REGISTER, 8'h10, 4'h1, -16'sd100, -16'sd100, 15'd1000,
              15'd1000);
    send_item(aabbct_pkg::OP_REGISTER, 8'h11, 4'h2, 16'd0, 16'd0, 15'd10, 15'd10);
    send_item(aabbct_pkg::OP_REGISTER, 8'h12, 4'h3, 16'd900, 16'd0, 15'd5, 15'd5);
    send_item(aabbct_pkg::OP_REGISTER, 8'h11, 4'h4, 16'd905, 16'd5, 15'd0, 15'd0);
    send_item(aabbct_pkg::OP_REGISTER, 8'h20, 4'h5, 16'h8000, 16'h7fff, 15'h7fff,
              15'h0000);
    send_item(aabbct_pkg::OP_REGISTER, 8'h21, 4'h6, 16'd20000, 16'h8000, 15'h7fff,
              15'h7fff);
    send_item(aabbct_pkg::OP_REGISTER, 8'h30, 4'h7, 16'd0, 16'd0, 15'd1, 15'd1);
    send_item(aabbct_pkg::OP_CHECK, 8'hff, 4'hf, 16'hffff, 16'hffff, 15'h7fff, 15'h7fff);
    send_item(aabbct_pkg::OP_UNREGISTER, 8'h11, 4'h9, 16'd0, 16'd0, 15'd0, 15'd0);
    send_item(OP_UNUSED, 8'hff, 4'hf, 16'hffff, 16'hffff, 15'h7fff, 15'h7fff);
    send_item(aabbct_pkg::OP_CHECK, 8'h00, 4'h0, 16'd0, 16'd0, 15'd0, 15'd0);
    send_item(aabbct_pkg::OP_UNREGISTER, 8'h77, 4'ha, 16'd0, 16'd0, 15'd0, 15'd0);
    send_item(aabbct_pkg::OP_UNREGISTER, 8'h00, 4'h0, 16'd0, 16'd0, 15'd0, 15'd0);
    send_item(aabbct_pkg::OP_UNREGISTER, 8'h21, 4'h6, 16'd0, 16'd0, 15'd0, 15'd0);
    send_item(aabbct_pkg::OP_CHECK, 8'h00, 4'h0, 16'd0, 16'd0, 15'd0, 15'd0);

    done_items = 0;
    while (done_items < RANDOM_ITEMS) begin
      no_gaps <= (done_items >= 60 && done_items < 100);
      send_random_item(counted);
      if (counted) done_items++;
    end
    in_tvalid <= 1'b0;
    no_gaps <= 1'b0;

    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("** aabb_all_pairs_collision_table: PASSED **");
    end else begin
      $display("** aabb_all_pairs_collision_table: FAILED **");
    end
    $finish;
  end

endmodule
